// ----- src/bcc_pkg.sv -----
// Shared constants, types and codes for the bipartite component checker.
package bcc_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int MAX_ENTRIES  = 8192;
  localparam int VW  = $clog2(MAX_VERTICES);      // vertex index width
  localparam int EW  = $clog2(MAX_ENTRIES);       // entry index width
  localparam int CW  = EW + 1;                    // entry count / degree width
  localparam int NW  = VW + 1;                    // vertex count width
  localparam int FIFO_DEPTH = 4;
  localparam int FW  = $clog2(FIFO_DEPTH);

  localparam logic [1:0] KIND_CLEAR  = 2'd0;
  localparam logic [1:0] KIND_APPEND = 2'd1;
  localparam logic [1:0] KIND_RUN    = 2'd2;

  localparam logic [1:0] COL_NONE = 2'd0;
  localparam logic [1:0] COL_SEED = 2'd1;
  localparam logic [1:0] COL_SUM  = 2'd3;

  typedef enum logic [1:0] {OP_CLEAR, OP_APPEND, OP_RUN} op_t;

  typedef struct packed {
    op_t           op;
    logic [VW-1:0] vertex;
    logic [VW-1:0] neighbour;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_CLR_ADJ, ST_IDLE, ST_CLR_COL, ST_SEED_RD, ST_SEED_CHK, ST_POP,
    ST_POP_W, ST_ADJ_W, ST_EDGE_RD, ST_EDGE_W, ST_COL_W, ST_DONE
  } state_t;

endpackage

// ----- src/bcc_ifs.sv -----
// Channel interfaces: request input, result output and configuration write.
interface bcc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [9:0] vertex;
  logic [9:0] neighbour;
  modport source (output valid, kind, vertex, neighbour, input ready);
  modport sink   (input valid, kind, vertex, neighbour, output ready);
endinterface

interface bcc_out_if;
  logic               valid;
  logic               ready;
  logic signed [11:0] signed_count;
  logic               is_bipartite;
  logic               load_error;
  modport source (output valid, signed_count, is_bipartite, load_error, input ready);
  modport sink   (input valid, signed_count, is_bipartite, load_error, output ready);
endinterface

interface bcc_cfg_if;
  logic        valid;
  logic        ready;
  logic [10:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ----- src/bcc_front.sv -----
// Front end: accept requests, decode the kind and drop unused codes.
module bcc_front (
  input  logic          clk,
  input  logic          rst_n,
  bcc_in_if.sink        in_chan,
  input  logic          fifo_full,
  output logic          push,
  output bcc_pkg::cmd_t cmd
);
  logic          cmd_v_r, cmd_v_nxt;
  bcc_pkg::cmd_t cmd_r, cmd_nxt;
  logic          take;
  logic          known;
  bcc_pkg::op_t  op;

  assign push          = cmd_v_r && !fifo_full;
  assign in_chan.ready = !cmd_v_r || !fifo_full;
  assign take          = in_chan.valid && in_chan.ready;
  assign cmd           = cmd_r;

  always_comb begin
    known = 1'b1;
    op    = bcc_pkg::OP_CLEAR;
    unique case (in_chan.kind)
      bcc_pkg::KIND_CLEAR:  op = bcc_pkg::OP_CLEAR;
      bcc_pkg::KIND_APPEND: op = bcc_pkg::OP_APPEND;
      bcc_pkg::KIND_RUN:    op = bcc_pkg::OP_RUN;
      default:              known = 1'b0;
    endcase
  end

  always_comb begin
    cmd_v_nxt = cmd_v_r && !push;
    cmd_nxt   = cmd_r;
    if (take) begin
      cmd_v_nxt = known;
      cmd_nxt   = '{op: op, vertex: in_chan.vertex, neighbour: in_chan.neighbour};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_v_r <= 1'b0;
    end else begin
      cmd_v_r <= cmd_v_nxt;
    end
    cmd_r <= cmd_nxt;
  end
endmodule

// ----- src/bcc_fifo.sv -----
// Short command queue between the front end and the graph engine.
module bcc_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  bcc_pkg::cmd_t push_cmd,
  input  logic          pop,
  output logic          full,
  output logic          empty,
  output bcc_pkg::cmd_t head_cmd
);
  bcc_pkg::cmd_t            slot_r [bcc_pkg::FIFO_DEPTH];
  logic [bcc_pkg::FW-1:0]   wr_r, wr_nxt, rd_r, rd_nxt;
  logic [bcc_pkg::FW:0]     cnt_r, cnt_nxt;

  assign full     = cnt_r == (bcc_pkg::FW+1)'(bcc_pkg::FIFO_DEPTH);
  assign empty    = cnt_r == '0;
  assign head_cmd = slot_r[rd_r];

  always_comb begin
    wr_nxt  = push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + (bcc_pkg::FW+1)'(push) - (bcc_pkg::FW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      slot_r[wr_r] <= push_cmd;
    end
  end
endmodule

// ----- src/bcc_back.sv -----
// Graph engine: adjacency store, loading, BFS two-coloring and result register.
module bcc_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          empty,
  input  bcc_pkg::cmd_t cmd,
  output logic          pop,
  input  logic [10:0]   vertex_count,
  bcc_out_if.source     out_chan
);
  localparam int VW = bcc_pkg::VW;
  localparam int EW = bcc_pkg::EW;
  localparam int CW = bcc_pkg::CW;
  localparam int NW = bcc_pkg::NW;
  localparam int AW = EW + CW;

  // memories
  logic [AW-1:0] adj_mem [bcc_pkg::MAX_VERTICES];
  logic [VW-1:0] nb_mem  [bcc_pkg::MAX_ENTRIES];
  logic [1:0]    col_mem [bcc_pkg::MAX_VERTICES];
  logic [VW-1:0] q_mem   [bcc_pkg::MAX_VERTICES];

  logic          adj_we, nb_we, col_we, q_we;
  logic [VW-1:0] adj_waddr, col_waddr, q_waddr, adj_raddr, col_raddr, q_raddr;
  logic [EW-1:0] nb_waddr, nb_raddr;
  logic [AW-1:0] adj_wdata, adj_rdata;
  logic [VW-1:0] nb_wdata, nb_rdata, q_wdata, q_rdata;
  logic [1:0]    col_wdata, col_rdata;

  bcc_pkg::state_t state_r, state_nxt;
  logic [CW-1:0] ent_r, ent_nxt, cur_deg_r, cur_deg_nxt, deg_r, deg_nxt, e_r, e_nxt;
  logic [EW-1:0] cur_start_r, cur_start_nxt, start_r, start_nxt;
  logic [VW-1:0] last_r, last_nxt, q_r, q_nxt;
  logic          err_r, err_nxt, proper_r, proper_nxt;
  logic [NW-1:0] n_r, n_nxt, s_r, s_nxt, head_r, head_nxt, tail_r, tail_nxt;
  logic [NW-1:0] comps_r, comps_nxt;
  logic [1:0]    pc_r, pc_nxt;
  logic          ov_r, ov_nxt;
  logic signed [11:0] oc_r, oc_nxt;
  logic          ob_r, ob_nxt, oe_r, oe_nxt;

  logic          app_bad, app_new, q_in_range, out_free, s_last;
  logic [NW-1:0] n_clamp;

  assign n_clamp    = (vertex_count > NW'(bcc_pkg::MAX_VERTICES)) ?
                      NW'(bcc_pkg::MAX_VERTICES) : vertex_count;
  assign app_bad    = (ent_r == CW'(bcc_pkg::MAX_ENTRIES)) ||
                      ((ent_r != '0) && (cmd.vertex < last_r));
  assign app_new    = (ent_r == '0) || (cmd.vertex != last_r);
  assign q_in_range = {1'b0, nb_rdata} < n_r;
  assign out_free   = !ov_r || out_chan.ready;
  assign s_last     = (s_r + 1'b1) == n_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bcc_pkg::ST_CLR_ADJ:
        if (s_r == NW'(bcc_pkg::MAX_VERTICES - 1)) state_nxt = bcc_pkg::ST_IDLE;
      bcc_pkg::ST_IDLE:
        if (!empty) begin
          unique case (cmd.op)
            bcc_pkg::OP_CLEAR:  state_nxt = bcc_pkg::ST_CLR_ADJ;
            bcc_pkg::OP_APPEND: state_nxt = bcc_pkg::ST_IDLE;
            bcc_pkg::OP_RUN:
              state_nxt = (n_clamp == '0) ? bcc_pkg::ST_DONE : bcc_pkg::ST_CLR_COL;
            default:            state_nxt = bcc_pkg::ST_IDLE;
          endcase
        end
      bcc_pkg::ST_CLR_COL:  if (s_last) state_nxt = bcc_pkg::ST_SEED_RD;
      bcc_pkg::ST_SEED_RD:  state_nxt = bcc_pkg::ST_SEED_CHK;
      bcc_pkg::ST_SEED_CHK:
        if (col_rdata == bcc_pkg::COL_NONE) state_nxt = bcc_pkg::ST_POP;
        else state_nxt = s_last ? bcc_pkg::ST_DONE : bcc_pkg::ST_SEED_RD;
      bcc_pkg::ST_POP:
        if (head_r != tail_r) state_nxt = bcc_pkg::ST_POP_W;
        else state_nxt = s_last ? bcc_pkg::ST_DONE : bcc_pkg::ST_SEED_RD;
      bcc_pkg::ST_POP_W:    state_nxt = bcc_pkg::ST_ADJ_W;
      bcc_pkg::ST_ADJ_W:    state_nxt = bcc_pkg::ST_EDGE_RD;
      bcc_pkg::ST_EDGE_RD:
        state_nxt = (e_r == deg_r) ? bcc_pkg::ST_POP : bcc_pkg::ST_EDGE_W;
      bcc_pkg::ST_EDGE_W:
        state_nxt = q_in_range ? bcc_pkg::ST_COL_W : bcc_pkg::ST_EDGE_RD;
      bcc_pkg::ST_COL_W:    state_nxt = bcc_pkg::ST_EDGE_RD;
      bcc_pkg::ST_DONE:     if (out_free) state_nxt = bcc_pkg::ST_IDLE;
      default:              state_nxt = bcc_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    pop = 1'b0;
    adj_we = 1'b0; nb_we = 1'b0; col_we = 1'b0; q_we = 1'b0;
    adj_waddr = cmd.vertex; adj_wdata = '0;
    nb_waddr = ent_r[EW-1:0]; nb_wdata = cmd.neighbour;
    col_waddr = s_r[VW-1:0]; col_wdata = bcc_pkg::COL_NONE;
    q_waddr = tail_r[VW-1:0]; q_wdata = s_r[VW-1:0];
    adj_raddr = q_rdata; col_raddr = s_r[VW-1:0]; q_raddr = head_r[VW-1:0];
    nb_raddr = start_r + e_r[EW-1:0];
    ent_nxt = ent_r; last_nxt = last_r; err_nxt = err_r;
    cur_start_nxt = cur_start_r; cur_deg_nxt = cur_deg_r;
    n_nxt = n_r; s_nxt = s_r; head_nxt = head_r; tail_nxt = tail_r;
    comps_nxt = comps_r; proper_nxt = proper_r; pc_nxt = pc_r;
    start_nxt = start_r; deg_nxt = deg_r; e_nxt = e_r; q_nxt = q_r;
    ov_nxt = ov_r && !out_chan.ready; oc_nxt = oc_r; ob_nxt = ob_r; oe_nxt = oe_r;
    unique case (state_r)
      bcc_pkg::ST_CLR_ADJ: begin
        adj_we    = 1'b1;
        adj_waddr = s_r[VW-1:0];
        s_nxt     = s_r + 1'b1;
      end
      bcc_pkg::ST_IDLE:
        if (!empty) begin
          pop = 1'b1;
          unique case (cmd.op)
            bcc_pkg::OP_CLEAR: begin
              ent_nxt = '0; last_nxt = '0; err_nxt = 1'b0; s_nxt = '0;
            end
            bcc_pkg::OP_APPEND:
              if (app_bad) begin
                err_nxt = 1'b1;
              end else begin
                cur_start_nxt = app_new ? ent_r[EW-1:0] : cur_start_r;
                cur_deg_nxt   = app_new ? CW'(1) : cur_deg_r + 1'b1;
                adj_we    = 1'b1;
                adj_wdata = {cur_start_nxt, cur_deg_nxt};
                nb_we     = 1'b1;
                ent_nxt   = ent_r + 1'b1;
                last_nxt  = cmd.vertex;
              end
            bcc_pkg::OP_RUN: begin
              n_nxt = n_clamp; s_nxt = '0; comps_nxt = '0; proper_nxt = 1'b1;
            end
            default: ;
          endcase
        end
      bcc_pkg::ST_CLR_COL: begin
        col_we = 1'b1;
        s_nxt  = s_last ? '0 : s_r + 1'b1;
      end
      bcc_pkg::ST_SEED_RD: ;
      bcc_pkg::ST_SEED_CHK:
        if (col_rdata == bcc_pkg::COL_NONE) begin
          col_we = 1'b1; col_wdata = bcc_pkg::COL_SEED;
          q_we = 1'b1; q_waddr = '0;
          head_nxt = '0; tail_nxt = NW'(1);
          comps_nxt = comps_r + 1'b1;
        end else begin
          s_nxt = s_r + 1'b1;
        end
      bcc_pkg::ST_POP:
        if (head_r != tail_r) head_nxt = head_r + 1'b1;
        else s_nxt = s_r + 1'b1;
      bcc_pkg::ST_POP_W: col_raddr = q_rdata;
      bcc_pkg::ST_ADJ_W: begin
        start_nxt = adj_rdata[AW-1:CW];
        deg_nxt   = adj_rdata[CW-1:0];
        pc_nxt    = col_rdata;
        e_nxt     = '0;
      end
      bcc_pkg::ST_EDGE_RD: ;
      bcc_pkg::ST_EDGE_W: begin
        q_nxt     = nb_rdata;
        col_raddr = nb_rdata;
        if (!q_in_range) e_nxt = e_r + 1'b1;
      end
      bcc_pkg::ST_COL_W: begin
        e_nxt = e_r + 1'b1;
        if (col_rdata == bcc_pkg::COL_NONE) begin
          col_we = 1'b1; col_waddr = q_r; col_wdata = bcc_pkg::COL_SUM - pc_r;
          q_we = 1'b1; q_wdata = q_r;
          tail_nxt = tail_r + 1'b1;
        end else if (col_rdata == pc_r) begin
          proper_nxt = 1'b0;
        end
      end
      bcc_pkg::ST_DONE:
        if (out_free) begin
          ov_nxt = 1'b1;
          oc_nxt = proper_r ? signed'({1'b0, comps_r}) : -signed'({1'b0, comps_r});
          ob_nxt = proper_r;
          oe_nxt = err_r;
        end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adj_we) adj_mem[adj_waddr] <= adj_wdata;
    if (nb_we)  nb_mem[nb_waddr]   <= nb_wdata;
    if (col_we) col_mem[col_waddr] <= col_wdata;
    if (q_we)   q_mem[q_waddr]     <= q_wdata;
    adj_rdata <= adj_mem[adj_raddr];
    nb_rdata  <= nb_mem[nb_raddr];
    col_rdata <= col_mem[col_raddr];
    q_rdata   <= q_mem[q_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bcc_pkg::ST_CLR_ADJ;
      s_r     <= '0;
      ent_r   <= '0;
      last_r  <= '0;
      err_r   <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      s_r     <= s_nxt;
      ent_r   <= ent_nxt;
      last_r  <= last_nxt;
      err_r   <= err_nxt;
      ov_r    <= ov_nxt;
    end
    cur_start_r <= cur_start_nxt; cur_deg_r <= cur_deg_nxt;
    n_r <= n_nxt; head_r <= head_nxt; tail_r <= tail_nxt;
    comps_r <= comps_nxt; proper_r <= proper_nxt; pc_r <= pc_nxt;
    start_r <= start_nxt; deg_r <= deg_nxt; e_r <= e_nxt; q_r <= q_nxt;
    oc_r <= oc_nxt; ob_r <= ob_nxt; oe_r <= oe_nxt;
  end

  assign out_chan.valid        = ov_r;
  assign out_chan.signed_count = oc_r;
  assign out_chan.is_bipartite = ob_r;
  assign out_chan.load_error   = oe_r;
endmodule

// ----- src/bipartite_component_check.sv -----
// Top level of the bipartite component checker: front end, queue, graph engine.
// A clear or append request is taken one per cycle while the queue is not full;
//   a clear then blocks the engine while the degree store is zeroed.
// A run makes one color-store sweep and a seed scan, with four steps per popped
//   vertex and a read, check and color step per entry on an in-range list; an
//   entry whose neighbour is out of range skips the color step.
// Reset: synchronous active-low; the engine then zeroes the degree store
//   before it carries out requests; vertex_count resets to 1.
module bipartite_component_check (
  input  logic      clk,
  input  logic      rst_n,
  bcc_in_if.sink    in_chan,
  bcc_out_if.source out_chan,
  bcc_cfg_if.sink   cfg_chan
);
  logic          push, fifo_full, fifo_empty, fifo_pop;
  bcc_pkg::cmd_t front_cmd, head_cmd;
  logic [10:0]   vcount_r, vcount_nxt;

  // vertex_count register; the host writes it only while no request is in flight (not enforced here)
  assign cfg_chan.ready = 1'b1;
  assign vcount_nxt     = cfg_chan.valid ? cfg_chan.data : vcount_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= 11'd1;
    end else begin
      vcount_r <= vcount_nxt;
    end
  end

  // decode requests and drop the unused kind
  bcc_front u_front (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan),
    .fifo_full(fifo_full), .push(push), .cmd(front_cmd)
  );

  // hold decoded requests so loading continues while a result waits
  bcc_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .push(push), .push_cmd(front_cmd),
    .pop(fifo_pop), .full(fifo_full), .empty(fifo_empty), .head_cmd(head_cmd)
  );

  // load edges, run BFS two-coloring, register the result
  bcc_back u_back (
    .clk(clk), .rst_n(rst_n), .empty(fifo_empty), .cmd(head_cmd),
    .pop(fifo_pop), .vertex_count(vcount_r), .out_chan(out_chan)
  );
endmodule

// ----- sim/bcc_tb_ifs.sv -----
// Shared request and verdict types for the testbench.
`timescale 1ns / 100ps
package bcc_tb_pkg;

  typedef struct {
    logic [1:0] kind;
    logic [9:0] vertex;
    logic [9:0] neighbour;
  } request_t;

  typedef struct {
    logic signed [11:0] signed_count;
    logic               is_bipartite;
    logic               load_error;
  } verdict_t;
endpackage

// ----- sim/testbench.sv -----
// Top-level testbench: drives graph requests and checks run verdicts against a BFS predictor.
`timescale 1ns / 100ps
module testbench;

  logic clk;
  logic rst_n;
  bcc_in_if  in_chan ();
  bcc_out_if out_chan ();
  bcc_cfg_if cfg_chan ();

  bipartite_component_check u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_chan(in_chan), .out_chan(out_chan), .cfg_chan(cfg_chan)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Shadow copy of the block's graph state.
  int unsigned          adj_list[bcc_pkg::MAX_VERTICES][$];
  int unsigned          shadow_entries;
  int unsigned          shadow_last;
  bit                   shadow_error;
  int unsigned          shadow_n;
  bcc_tb_pkg::verdict_t pending_verdicts[$];
  int                   errors;
  longint               cycle_count;
  bit                   hold_off;

  // Apply one request to the shadow graph; a run pushes its expected verdict.
  function automatic void predict_request(bcc_tb_pkg::request_t r);
    int unsigned colour[bcc_pkg::MAX_VERTICES];
    int unsigned frontier[$];
    int unsigned n, comps, p, q;
    bit proper;
    bcc_tb_pkg::verdict_t v;
    case (r.kind)
      bcc_pkg::KIND_CLEAR: begin
        foreach (adj_list[i]) adj_list[i].delete();
        shadow_entries = 0;
        shadow_last = 0;
        shadow_error = 0;
      end
      bcc_pkg::KIND_APPEND: begin
        if (shadow_entries >= bcc_pkg::MAX_ENTRIES ||
            (shadow_entries > 0 && r.vertex < shadow_last)) begin
          shadow_error = 1;
        end else begin
          // a new list for a vertex restarts its degree
          if (shadow_entries == 0 || r.vertex != shadow_last) adj_list[r.vertex].delete();
          adj_list[r.vertex].push_back(r.neighbour);
          shadow_entries++;
          shadow_last = r.vertex;
        end
      end
      bcc_pkg::KIND_RUN: begin
        n = (shadow_n > bcc_pkg::MAX_VERTICES) ? bcc_pkg::MAX_VERTICES : shadow_n;
        comps = 0;
        proper = 1;
        foreach (colour[i]) colour[i] = bcc_pkg::COL_NONE;
        for (int s = 0; s < n; s++) begin
          if (colour[s] != bcc_pkg::COL_NONE) continue;
          colour[s] = bcc_pkg::COL_SEED;
          comps++;
          frontier.delete();
          frontier.push_back(s);
          while (frontier.size() > 0) begin
            p = frontier.pop_front();
            foreach (adj_list[p][e]) begin
              q = adj_list[p][e];
              if (q < n && colour[q] == bcc_pkg::COL_NONE) begin
                colour[q] = bcc_pkg::COL_SUM - colour[p];
                frontier.push_back(q);
              end
            end
          end
        end
        for (int u = 0; u < n && proper; u++)
          foreach (adj_list[u][e])
            if (adj_list[u][e] < n && colour[adj_list[u][e]] == colour[u]) proper = 0;
        v.signed_count = 12'(proper ? comps : -comps);
        v.is_bipartite = proper;
        v.load_error = shadow_error;
        pending_verdicts.push_back(v);
      end
      default: ;
    endcase
  endfunction

  // Sender: offer one request, with a random gap before it.
  task automatic send_request(bcc_tb_pkg::request_t r);
    int unsigned gap;
    gap = $urandom_range(0, 16);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.kind <= r.kind;
    in_chan.vertex <= r.vertex;
    in_chan.neighbour <= r.neighbour;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    predict_request(r);
    @(negedge clk);
  endtask

  // Drop the input, wait until all verdicts are in, then idle past a pending degree clear.
  task automatic drain_and_settle();
    in_chan.valid <= 1'b0;
    while (pending_verdicts.size() > 0) @(negedge clk);
    repeat (1100) @(negedge clk);
  endtask

  task automatic write_vertex_count(int unsigned value);
    cfg_chan.valid <= 1'b1;
    cfg_chan.data <= value[10:0];
    @(posedge clk);
    while (!cfg_chan.ready) @(posedge clk);
    shadow_n = 32'(value[10:0]);
    @(negedge clk);
    cfg_chan.valid <= 1'b0;
  endtask

  // Clear, load a random graph on nv vertices, then run.
  task automatic random_graph(int unsigned nv, int unsigned edges);
    bcc_tb_pkg::request_t r;
    int unsigned v;
    r.kind = bcc_pkg::KIND_CLEAR; r.vertex = 10'($urandom); r.neighbour = 10'($urandom);
    send_request(r);
    v = 0;
    for (int i = 0; i < edges; i++) begin
      r.kind = bcc_pkg::KIND_APPEND;
      if ($urandom_range(0, 19) == 0) v = $urandom_range(0, 1023);  // noise, may misorder
      else if ($urandom_range(0, 2) == 0 && v + 1 < nv) v = $urandom_range(v, nv - 1);
      r.vertex = v[9:0];
      r.neighbour = ($urandom_range(0, 15) == 0) ? 10'($urandom_range(0, 1023))
                                                 : 10'($urandom_range(0, nv - 1));
      send_request(r);
      if ($urandom_range(0, 39) == 0) begin
        r.kind = 2'd3; send_request(r);
      end
    end
    r.kind = bcc_pkg::KIND_RUN;
    send_request(r);
  endtask

  // Receiver: random wait per verdict, plus one long hold-off when requested.
  initial begin
    int unsigned gap;
    out_chan.ready = 1'b0;
    forever begin
      if (hold_off) begin
        gap = 20000;
        hold_off = 0;
      end else begin
        gap = $urandom_range(0, 16);
      end
      if (gap > 0) begin
        out_chan.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_chan.ready <= 1'b1;
      @(posedge clk);
      while (!out_chan.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Check each verdict against the oldest expectation.
  always @(posedge clk) begin
    bcc_tb_pkg::verdict_t exp_v;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_verdicts.size() == 0) begin
        $error("unexpected verdict %0d", out_chan.signed_count);
        errors++;
      end else begin
        exp_v = pending_verdicts.pop_front();
        if (out_chan.signed_count !== exp_v.signed_count) begin
          $error("signed_count expected %0d got %0d", exp_v.signed_count,
                 out_chan.signed_count);
          errors++;
        end
        if (out_chan.is_bipartite !== exp_v.is_bipartite) begin
          $error("is_bipartite expected %0b got %0b", exp_v.is_bipartite,
                 out_chan.is_bipartite);
          errors++;
        end
        if (out_chan.load_error !== exp_v.load_error) begin
          $error("load_error expected %0b got %0b", exp_v.load_error, out_chan.load_error);
          errors++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 4000000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Directed table: kind, vertex, neighbour.
  localparam int DIR_ROWS = 14;
  logic [21:0] directed_rows[DIR_ROWS] = '{
    {bcc_pkg::KIND_RUN, 10'd0, 10'd0},          // vertex count still 0: zero vertices, count 0
    {bcc_pkg::KIND_APPEND, 10'd0, 10'd1},
    {bcc_pkg::KIND_APPEND, 10'd1, 10'd0},
    {bcc_pkg::KIND_APPEND, 10'd1, 10'd2},
    {bcc_pkg::KIND_APPEND, 10'd2, 10'd0},       // triangle 0-1-2
    {bcc_pkg::KIND_APPEND, 10'd1, 10'd3},       // misordered: dropped
    {2'd3, 10'd1023, 10'd1023},                 // unused kind
    {bcc_pkg::KIND_RUN, 10'd0, 10'd0},
    {bcc_pkg::KIND_CLEAR, 10'd1023, 10'd1023},
    {bcc_pkg::KIND_APPEND, 10'd0, 10'd1023},
    {bcc_pkg::KIND_APPEND, 10'd1023, 10'd0},
    {bcc_pkg::KIND_RUN, 10'd0, 10'd0},
    {bcc_pkg::KIND_CLEAR, 10'd0, 10'd0},
    {bcc_pkg::KIND_RUN, 10'd0, 10'd0}
  };

  initial begin
    bcc_tb_pkg::request_t r;
    errors = 0; cycle_count = 0; hold_off = 0; shadow_n = 1;
    foreach (adj_list[i]) adj_list[i].delete();
    shadow_entries = 0; shadow_last = 0; shadow_error = 0;
    rst_n = 1'b0;
    in_chan.valid = 1'b0; in_chan.kind = '0; in_chan.vertex = '0; in_chan.neighbour = '0;
    cfg_chan.valid = 1'b0; cfg_chan.data = '0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    // first run at reset count: single vertex, bipartite, clean load
    pending_verdicts.push_back('{12'sd1, 1'b1, 1'b0});
    r.kind = bcc_pkg::KIND_RUN; r.vertex = 0; r.neighbour = 0;
    send_request(r);
    pending_verdicts.pop_back();   // predictor already pushed the same row
    drain_and_settle();
    write_vertex_count(0);
    send_request(r);               // zero vertices gives count 0
    drain_and_settle();
    foreach (directed_rows[i]) begin
      if (i == 1) begin
        drain_and_settle(); write_vertex_count(3);
      end
      if (i == 11) begin
        drain_and_settle(); write_vertex_count(2047);   // clamps to full size
      end
      r.kind = directed_rows[i][21:20];
      r.vertex = directed_rows[i][19:10];
      r.neighbour = directed_rows[i][9:0];
      send_request(r);
    end
    drain_and_settle();
    write_vertex_count(1024);
    hold_off = 1;                  // stall results so the block backs up
    for (int k = 0; k < 6; k++) random_graph(1024, 2);
    drain_and_settle();
    for (int ph = 0; ph < 4; ph++) begin
      write_vertex_count($urandom_range(1, 24));
      for (int k = 0; k < 11; k++) random_graph(shadow_n + 2, $urandom_range(0, 30));
      drain_and_settle();
    end
    write_vertex_count(1);
    random_graph(3, 4);
    drain_and_settle();
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
